>>> src/c2b_pkg.sv
// shared constants, register indexes and the cordic angle table for the beam gate
package c2b_pkg;

    localparam int MAX_BEAMS_DEF = 1024;
    localparam int CFG_W         = 18;
    localparam int IDX_W         = 3;
    localparam int CORDIC_STEPS  = 20;
    localparam int SQRT_STEPS    = 19;
    localparam int STEP_W        = 5;
    localparam int DIV_NUM_W     = 18;
    localparam int DIV_DEN_W     = 16;

    localparam logic [IDX_W-1:0] REG_SENSOR_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SENSOR_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_ANGLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_ANGLE = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_DIST  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_DIST  = 3'd5;
    localparam logic [IDX_W-1:0] REG_ANG_RES   = 3'd6;

    localparam logic signed [23:0] PI_Q20 = 24'sd3294199;

    // atan(2^-i) in q20 radians
    function automatic logic signed [23:0] atan_q20(input logic [STEP_W-1:0] i);
        logic signed [23:0] v;
        case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/c2b_if.sv
// valid/ready channels for sample points and beams
interface c2b_point_if;
    logic                valid;
    logic                ready;
    logic signed [17:0]  point_x;
    logic signed [17:0]  point_y;
    logic                first_point;
    modport source (output valid, point_x, point_y, first_point, input ready);
    modport sink   (input valid, point_x, point_y, first_point, output ready);
endinterface

interface c2b_beam_if;
    logic                valid;
    logic                ready;
    logic                beam_accepted;
    logic [17:0]         beam_range;
    logic signed [15:0]  beam_angle;
    logic [15:0]         beam_index;
    logic [9:0]          beam_slot;
    logic                list_full;
    modport source (output valid, beam_accepted, beam_range, beam_angle, beam_index,
                    beam_slot, list_full, input ready);
    modport sink   (input valid, beam_accepted, beam_range, beam_angle, beam_index,
                    beam_slot, list_full, output ready);
endinterface

>>> src/c2b_div.sv
// restoring divider, one quotient bit per cycle
module c2b_div #(
    parameter int NUM_W = c2b_pkg::DIV_NUM_W,
    parameter int DEN_W = c2b_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg[DEN_W-1:0], n_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, d_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            n_next   = numer;
            rem_next = '0;
            d_next   = denom;
        end
        else if (run_reg)
        begin
            n_next   = {n_reg[NUM_W-2:0], 1'b0};
            q_next   = {q_reg[NUM_W-2:0], fits};
            rem_next = fits ? shifted - {1'b0, d_reg} : shifted;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

>>> src/cartesian_to_beam_gate_unit.sv
// cartesian point to gated sensor beam converter, top level
// steps in order: square, cordic and sqrt iteration, gate, divide, output; the output step
//   waits while the beam channel is stalled
// one point at a time: a new beat is taken once the previous result is in the output register
// rejected points skip the divider
// reset: registers return to their listed defaults and the beam count clears
module cartesian_to_beam_gate_unit #(
    parameter int MAX_BEAMS = c2b_pkg::MAX_BEAMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [c2b_pkg::IDX_W-1:0]      cfg_index,
    input  logic [c2b_pkg::CFG_W-1:0]      cfg_data,
    c2b_point_if.sink                      point,
    c2b_beam_if.source                     beam
);
    localparam int CNT_W = $clog2(MAX_BEAMS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_ITER = 6'b000100,
        ST_GATE = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [17:0] sensor_x_reg, sensor_y_reg;
    logic signed [15:0] min_angle_reg, max_angle_reg;
    logic [17:0]        min_dist_reg, max_dist_reg;
    logic [14:0]        ang_res_reg;

    logic [CNT_W-1:0]   count_reg;
    logic               phase_reg;
    logic [c2b_pkg::STEP_W-1:0] step_reg;

    logic signed [18:0] dx_reg, dy_reg;
    logic [36:0]        sum_reg;
    logic [36:0]        rem_reg, root_reg, bit_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [23:0] z_reg;
    logic               pass_reg;
    logic [17:0]        range_reg;
    logic signed [15:0] angle_reg;

    logic               accept;
    logic signed [18:0] mul_a;
    logic signed [37:0] prod;
    logic [36:0]        trial;
    logic signed [33:0] xs, ys;
    logic signed [23:0] z_round;
    logic signed [16:0] ang17;
    logic [18:0]        range19;
    logic               pass;
    logic signed [17:0] num;
    logic [14:0]        res;
    logic [17:0]        div_numer;
    logic [15:0]        div_denom;
    logic               div_done;
    logic [17:0]        div_quot;
    logic               div_start;
    logic               out_free;
    logic [15:0]        index_reg;
    logic signed [18:0] dxn, dyn;

    assign accept   = point.valid && point.ready;
    assign point.ready = (state_reg == ST_IDLE);
    assign out_free = !beam.valid || beam.ready;

    // shared squarer
    assign mul_a = phase_reg ? dy_reg : dx_reg;
    assign prod  = mul_a * mul_a;

    assign trial = root_reg + bit_reg;
    assign xs    = x_reg >>> step_reg;
    assign ys    = y_reg >>> step_reg;

    assign z_round = z_reg + 24'sd64;
    assign ang17   = z_round[23:7];
    assign range19 = (rem_reg > root_reg) ? root_reg[18:0] + 19'd1 : root_reg[18:0];
    assign pass    = (ang17 >= 17'(min_angle_reg)) && (ang17 <= 17'(max_angle_reg))
                   && (range19 > {1'b0, min_dist_reg}) && (range19 < {1'b0, max_dist_reg});
    assign num       = 18'(ang17) - 18'(min_angle_reg);
    assign res       = (ang_res_reg == '0) ? 15'd1 : ang_res_reg;
    assign div_numer = {num[16:0], 1'b0} + {3'd0, res};
    assign div_denom = {res, 1'b0};
    assign div_start = (state_reg == ST_GATE) && pass;

    assign dxn = -dx_reg;
    assign dyn = -dy_reg;

    c2b_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SQ;
            ST_SQ:   if (phase_reg) state_next = ST_ITER;
            ST_ITER: if (step_reg == c2b_pkg::STEP_W'(c2b_pkg::CORDIC_STEPS - 1))
                         state_next = ST_GATE;
            ST_GATE: state_next = pass ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sensor_x_reg  <= '0;
            sensor_y_reg  <= '0;
            min_angle_reg <= -16'sd25736;
            max_angle_reg <= 16'sd25736;
            min_dist_reg  <= '0;
            max_dist_reg  <= 18'd185364;
            ang_res_reg   <= 15'd143;
            count_reg     <= '0;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            beam.valid    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    c2b_pkg::REG_SENSOR_X:  sensor_x_reg  <= cfg_data;
                    c2b_pkg::REG_SENSOR_Y:  sensor_y_reg  <= cfg_data;
                    c2b_pkg::REG_MIN_ANGLE: min_angle_reg <= cfg_data[15:0];
                    c2b_pkg::REG_MAX_ANGLE: max_angle_reg <= cfg_data[15:0];
                    c2b_pkg::REG_MIN_DIST:  min_dist_reg  <= cfg_data;
                    c2b_pkg::REG_MAX_DIST:  max_dist_reg  <= cfg_data;
                    c2b_pkg::REG_ANG_RES:   ang_res_reg   <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (accept && point.first_point)
                count_reg <= '0;
            if (state_reg == ST_IDLE)
                phase_reg <= 1'b0;
            else if (state_reg == ST_SQ)
                phase_reg <= 1'b1;
            if (state_reg == ST_ITER)
                step_reg <= step_reg + 1'b1;
            else
                step_reg <= '0;
            if ((state_reg == ST_OUT) && out_free)
            begin
                beam.valid <= 1'b1;
                if (pass_reg && (count_reg < CNT_W'(MAX_BEAMS)))
                    count_reg <= count_reg + 1'b1;
            end
            else if (beam.valid && beam.ready)
                beam.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= 19'(point.point_x) - 19'(sensor_x_reg);
            dy_reg <= 19'(point.point_y) - 19'(sensor_y_reg);
        end
        if (state_reg == ST_SQ)
        begin
            if (!phase_reg)
            begin
                sum_reg <= prod[36:0];
                // left half plane is folded over by a half turn
                if (dx_reg < 0)
                begin
                    x_reg <= 34'(dxn) <<< 12;
                    y_reg <= 34'(dyn) <<< 12;
                    z_reg <= (dy_reg >= 0) ? c2b_pkg::PI_Q20 : -c2b_pkg::PI_Q20;
                end
                else
                begin
                    x_reg <= 34'(dx_reg) <<< 12;
                    y_reg <= 34'(dy_reg) <<< 12;
                    z_reg <= '0;
                end
            end
            else
            begin
                rem_reg  <= sum_reg + prod[36:0];
                root_reg <= '0;
                bit_reg  <= 37'd1 << 36;
            end
        end
        if (state_reg == ST_ITER)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + c2b_pkg::atan_q20(step_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - c2b_pkg::atan_q20(step_reg);
            end
            if (step_reg < c2b_pkg::STEP_W'(c2b_pkg::SQRT_STEPS))
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
        end
        if (state_reg == ST_GATE)
        begin
            pass_reg  <= pass;
            range_reg <= range19[17:0];
            angle_reg <= ang17[15:0];
        end
        if (div_done)
            index_reg <= div_quot[15:0];
        if ((state_reg == ST_OUT) && out_free)
        begin
            if (pass_reg)
            begin
                beam.beam_range <= range_reg;
                beam.beam_angle <= angle_reg;
                beam.beam_index <= index_reg;
                if (count_reg < CNT_W'(MAX_BEAMS))
                begin
                    beam.beam_accepted <= 1'b1;
                    beam.beam_slot     <= 10'(count_reg);
                    beam.list_full     <= 1'b0;
                end
                else
                begin
                    beam.beam_accepted <= 1'b0;
                    beam.beam_slot     <= '0;
                    beam.list_full     <= 1'b1;
                end
            end
            else
            begin
                beam.beam_accepted <= 1'b0;
                beam.list_full     <= 1'b0;
                beam.beam_slot     <= '0;
                beam.beam_range    <= '0;
                beam.beam_angle    <= '0;
                beam.beam_index    <= '0;
            end
        end
    end
endmodule
